@@ rtl/y2r_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants and types for the YUYV to RGB565 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int SIDE_W  = 13;
    localparam int TOTAL_W = 25;
    localparam int DONE_W  = 24;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 27;

    localparam logic [SIDE_W-1:0] MAX_SIDE      = 13'd4096;
    localparam logic [SIDE_W-1:0] WIDTH_RST     = 13'd176;
    localparam logic [SIDE_W-1:0] HEIGHT_RST    = 13'd220;
    localparam logic [TOTAL_W-1:0] TOTAL_RST    = 25'd38720;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Q16 coefficients
    localparam logic signed [SUM_W-1:0] COEF_RV = 27'sd91881;
    localparam logic signed [SUM_W-1:0] COEF_GU = 27'sd22554;
    localparam logic signed [SUM_W-1:0] COEF_GV = 27'sd46802;
    localparam logic signed [SUM_W-1:0] COEF_BU = 27'sd116130;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } t_yuyv;

    typedef struct packed {
        logic second_valid;
        logic frame_end;
    } t_flags;

    typedef struct packed {
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] guv;
        logic signed [SUM_W-1:0] bu;
    } t_prod;

endpackage
`default_nettype wire

@@ rtl/y2r_yuyv_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_yuyv_if
// YUYV macropixel channel: one word is Y0, U, Y1, V.
// ----------------------------------------------------------------------------
interface y2r_yuyv_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;

    modport source (
        output valid, luma_first, chroma_blue, luma_second, chroma_red,
        input  ready
    );
    modport sink (
        input  valid, luma_first, chroma_blue, luma_second, chroma_red,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/y2r_rgb_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_rgb_if
// RGB565 pixel pair channel with frame markers.
// ----------------------------------------------------------------------------
interface y2r_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        second_valid;
    logic        frame_end;

    modport source (
        output valid, pixel_first, pixel_second, second_valid, frame_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_first, pixel_second, second_valid, frame_end,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/y2r_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_cfg
// Frame size registers and the registered pixel count of one frame.
// ----------------------------------------------------------------------------
module y2r_cfg
    import y2r_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [SIDE_W-1:0]  i_cfg_data,
    output logic      [TOTAL_W-1:0] o_pix_total
);

    logic [SIDE_W-1:0]  r_width,  n_width;
    logic [SIDE_W-1:0]  r_height, n_height;
    logic [TOTAL_W-1:0] r_total,  n_total;

    function automatic logic [SIDE_W-1:0] side_eff(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] e;
        if (s == '0) begin
            e = SIDE_W'(1);
        end else if (s > MAX_SIDE) begin
            e = MAX_SIDE;
        end else begin
            e = s;
        end
        return e;
    endfunction

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we && i_cfg_idx == REG_FRAME_WIDTH) begin
            n_width = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_idx == REG_FRAME_HEIGHT) begin
            n_height = i_cfg_data;
        end
        // 4096 x 4096 needs the full 25 bits
        n_total = TOTAL_W'(side_eff(n_width)) * TOTAL_W'(side_eff(n_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_total  <= TOTAL_RST;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_total  <= n_total;
        end
    end

    assign o_pix_total = r_total;

endmodule
`default_nettype wire

@@ rtl/y2r_frame_cnt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_frame_cnt
// Input register and frame pixel counter; decides second_valid / frame_end.
// ----------------------------------------------------------------------------
module y2r_frame_cnt
    import y2r_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [TOTAL_W-1:0] i_pix_total,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_yuyv              i_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_yuyv                   o_word,
    output t_flags                  o_flags
);

    logic               r_valid;
    t_yuyv              r_word;
    t_flags             r_flags, n_flags;
    logic [DONE_W-1:0]  r_done,  n_done;
    logic [TOTAL_W-1:0] done_p1;
    logic [TOTAL_W-1:0] done_p2;
    logic               accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        done_p1 = {1'b0, r_done} + TOTAL_W'(1);
        done_p2 = {1'b0, r_done} + TOTAL_W'(2);
        if (done_p1 >= i_pix_total) begin
            n_flags.second_valid = 1'b0;
            n_flags.frame_end    = 1'b1;
        end else begin
            n_flags.second_valid = 1'b1;
            n_flags.frame_end    = (done_p2 >= i_pix_total);
        end
        n_done = n_flags.frame_end ? '0 : done_p2[DONE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_done <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_word;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

@@ rtl/y2r_chroma_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_chroma_mul
// Chroma products shared by both pixels of a macropixel, registered.
// ----------------------------------------------------------------------------
module y2r_chroma_mul
    import y2r_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_yuyv  i_word,
    input  wire t_flags i_flags,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_luma_first,
    output logic [7:0]  o_luma_second,
    output t_prod       o_prod,
    output t_flags      o_flags
);

    logic                    r_valid;
    logic [7:0]              r_y0;
    logic [7:0]              r_y1;
    t_prod                   r_prod, n_prod;
    t_flags                  r_flags;
    logic signed [SUM_W-1:0] u_s;
    logic signed [SUM_W-1:0] v_s;
    logic                    accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // offset binary to two's complement: flip the top bit
        u_s = SUM_W'($signed({~i_word.chroma_blue[7], i_word.chroma_blue[6:0]}));
        v_s = SUM_W'($signed({~i_word.chroma_red[7], i_word.chroma_red[6:0]}));
        n_prod.rv  = COEF_RV * v_s;
        n_prod.guv = COEF_GU * u_s + COEF_GV * v_s;
        n_prod.bu  = COEF_BU * u_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y0    <= i_word.luma_first;
            r_y1    <= i_word.luma_second;
            r_prod  <= n_prod;
            r_flags <= i_flags;
        end
    end

    assign o_valid       = r_valid;
    assign o_luma_first  = r_y0;
    assign o_luma_second = r_y1;
    assign o_prod        = r_prod;
    assign o_flags       = r_flags;

endmodule
`default_nettype wire

@@ rtl/y2r_pack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// y2r_pack
// Luma add, clamp to 0..255, 5-6-5 packing and the result register.
// ----------------------------------------------------------------------------
module y2r_pack
    import y2r_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_luma_first,
    input  wire logic [7:0]  i_luma_second,
    input  wire t_prod       i_prod,
    input  wire t_flags      i_flags,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_pixel_first,
    output logic [15:0]      o_pixel_second,
    output t_flags           o_flags
);

    logic        r_valid;
    logic [15:0] r_pix0, n_pix0;
    logic [15:0] r_pix1, n_pix1;
    t_flags      r_flags;
    logic        accept;

    function automatic logic [7:0] chan(input logic signed [SUM_W-1:0] q);
        logic [7:0] c;
        if (q[SUM_W-1]) begin
            c = 8'd0;
        end else if (|q[SUM_W-2:24]) begin
            c = 8'd255;
        end else begin
            c = q[23:16];
        end
        return c;
    endfunction

    function automatic logic [15:0] to565(input logic [7:0] y, input t_prod p);
        logic signed [SUM_W-1:0] ys;
        logic [7:0]              r;
        logic [7:0]              g;
        logic [7:0]              b;
        ys = $signed({3'b000, y, 16'h0000});
        r  = chan(ys + p.rv);
        g  = chan(ys - p.guv);
        b  = chan(ys + p.bu);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_pix0 = to565(i_luma_first, i_prod);
        n_pix1 = i_flags.second_valid ? to565(i_luma_second, i_prod) : 16'h0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix0  <= n_pix0;
            r_pix1  <= n_pix1;
            r_flags <= i_flags;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_first  = r_pix0;
    assign o_pixel_second = r_pix1;
    assign o_flags        = r_flags;

endmodule
`default_nettype wire

@@ rtl/yuyv_to_rgb565_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_converter
// YUYV macropixel to two RGB565 pixels (BT.601, Q16), with frame end marking.
// ----------------------------------------------------------------------------
//   channel   dir  word
//   i_yuyv    in   luma_first, chroma_blue, luma_second, chroma_red
//   o_rgb     out  pixel_first, pixel_second, second_valid, frame_end
//   i_cfg_*   in   register write: 0 frame_width, 1 frame_height
//
// One word per cycle sustained while o_rgb.ready is high; a taken word is
// registered in the counter, chroma multiply and clamp/pack stages in turn.
// Each stage holds its word while the next one stalls; o_rgb.ready low
// backs up through all three stages to i_yuyv.ready.
// Reset clears the pixel counter and loads width 176, height 220.
// ----------------------------------------------------------------------------
module yuyv_to_rgb565_converter
    import y2r_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [SIDE_W-1:0] i_cfg_data,
    y2r_yuyv_if.sink               i_yuyv,
    y2r_rgb_if.source              o_rgb
);

    logic [TOTAL_W-1:0] pix_total;
    t_yuyv              in_word;
    t_yuyv              s1_word;
    t_flags             s1_flags;
    logic               s1_valid;
    logic               s1_ready;
    logic               s2_valid;
    logic               s2_ready;
    logic [7:0]         s2_y0;
    logic [7:0]         s2_y1;
    t_prod              s2_prod;
    t_flags             s2_flags;
    t_flags             out_flags;

    assign in_word.luma_first  = i_yuyv.luma_first;
    assign in_word.chroma_blue = i_yuyv.chroma_blue;
    assign in_word.luma_second = i_yuyv.luma_second;
    assign in_word.chroma_red  = i_yuyv.chroma_red;

    y2r_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pix_total (pix_total)
    );

    y2r_frame_cnt u_frame_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_total (pix_total),
        .i_valid     (i_yuyv.valid),
        .o_ready     (i_yuyv.ready),
        .i_word      (in_word),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_word      (s1_word),
        .o_flags     (s1_flags)
    );

    y2r_chroma_mul u_chroma_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .o_ready       (s1_ready),
        .i_word        (s1_word),
        .i_flags       (s1_flags),
        .o_valid       (s2_valid),
        .i_ready       (s2_ready),
        .o_luma_first  (s2_y0),
        .o_luma_second (s2_y1),
        .o_prod        (s2_prod),
        .o_flags       (s2_flags)
    );

    y2r_pack u_pack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s2_valid),
        .o_ready        (s2_ready),
        .i_luma_first   (s2_y0),
        .i_luma_second  (s2_y1),
        .i_prod         (s2_prod),
        .i_flags        (s2_flags),
        .o_valid        (o_rgb.valid),
        .i_ready        (o_rgb.ready),
        .o_pixel_first  (o_rgb.pixel_first),
        .o_pixel_second (o_rgb.pixel_second),
        .o_flags        (out_flags)
    );

    assign o_rgb.second_valid = out_flags.second_valid;
    assign o_rgb.frame_end    = out_flags.frame_end;

endmodule
`default_nettype wire
